[hw/rtl/tdcs_pkg.sv]
package tdcs_pkg;

    localparam int COOL_TIMER_BITS = 23;

    localparam int OPEN_W    = 10;
    localparam int TPM_W     = 13;
    localparam int CYC_W     = 4;
    localparam int CNT_W     = 5;
    localparam int PHASE_W   = 10;
    localparam int MIN_W     = 10;
    localparam int CHOICE_W  = 3;
    localparam int AMT_W     = 2;
    localparam int BTN_W     = 3;
    localparam int REG_IDX_W = 3;

    localparam int DUR_W     = MIN_W + TPM_W;
    localparam int CMP_W     = (COOL_TIMER_BITS > DUR_W) ? COOL_TIMER_BITS : DUR_W;
    localparam int DIV_CNT_W = $clog2(COOL_TIMER_BITS + 1);

    localparam int IN_W  = 8;
    localparam int OUT_W = 40;

    localparam int BTN_MODE   = 0;
    localparam int BTN_AMOUNT = 1;
    localparam int BTN_COOL   = 2;

    localparam int AMOUNT_COUNT = 3;
    localparam int HUMAN_LEN    = 7;
    localparam int ANIMAL_LEN   = 6;

    localparam logic [OPEN_W-1:0] OPEN_TICKS_RST  = OPEN_W'(100);
    localparam logic [TPM_W-1:0]  TPM_RST         = TPM_W'(6000);
    localparam logic [CYC_W-1:0]  CYCLES_LOW_RST  = CYC_W'(5);
    localparam logic [CYC_W-1:0]  CYCLES_MED_RST  = CYC_W'(10);
    localparam logic [CYC_W-1:0]  CYCLES_HIGH_RST = CYC_W'(15);

    typedef enum logic [1:0] {
        CMD_NONE  = 2'd0,
        CMD_OPEN  = 2'd1,
        CMD_CLOSE = 2'd2
    } t_servo_cmd;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_OPEN_TICKS  = 3'd0,
        REG_TICKS_PER_MIN = 3'd1,
        REG_CYCLES_LOW  = 3'd2,
        REG_CYCLES_MED  = 3'd3,
        REG_CYCLES_HIGH = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic                       done;
        logic [COOL_TIMER_BITS-1:0] quot;
        logic [TPM_W-1:0]           rem;
    } t_div_res;

    function automatic logic [MIN_W-1:0] table_minutes(input logic mode,
                                                       input logic [CHOICE_W-1:0] choice);
        logic [MIN_W-1:0] m;
        m = '0;
        if (!mode) begin
            case (choice)
                3'd0: m = MIN_W'(0);
                3'd1: m = MIN_W'(5);
                3'd2: m = MIN_W'(10);
                3'd3: m = MIN_W'(15);
                3'd4: m = MIN_W'(30);
                3'd5: m = MIN_W'(45);
                3'd6: m = MIN_W'(60);
                default: m = '0;
            endcase
        end else begin
            case (choice)
                3'd0: m = MIN_W'(30);
                3'd1: m = MIN_W'(60);
                3'd2: m = MIN_W'(120);
                3'd3: m = MIN_W'(240);
                3'd4: m = MIN_W'(480);
                3'd5: m = MIN_W'(720);
                default: m = '0;
            endcase
        end
        return m;
    endfunction

endpackage

[hw/rtl/tdcs_div.sv]
module tdcs_div (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic [tdcs_pkg::COOL_TIMER_BITS-1:0] i_dividend,
    input  logic [tdcs_pkg::TPM_W-1:0]           i_divisor,
    output logic                                 o_busy,
    output tdcs_pkg::t_div_res                   o_res
);

    logic                                 r_busy;
    logic                                 r_done;
    logic [tdcs_pkg::DIV_CNT_W-1:0]       r_cnt;
    logic [tdcs_pkg::COOL_TIMER_BITS-1:0] r_acc;
    logic [tdcs_pkg::TPM_W-1:0]           r_rem;
    logic [tdcs_pkg::TPM_W-1:0]           r_den;

    logic [tdcs_pkg::TPM_W:0]             trial;
    logic                                 ge;
    logic [tdcs_pkg::TPM_W:0]             diff;

    always_comb begin
        trial = {r_rem, r_acc[tdcs_pkg::COOL_TIMER_BITS-1]};
        ge    = trial >= {1'b0, r_den};
        diff  = trial - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= tdcs_pkg::DIV_CNT_W'(tdcs_pkg::COOL_TIMER_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == tdcs_pkg::DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_acc <= i_dividend;
            r_rem <= '0;
            r_den <= i_divisor;
        end else if (r_busy) begin
            r_acc <= {r_acc[tdcs_pkg::COOL_TIMER_BITS-2:0], ge};
            r_rem <= ge ? diff[tdcs_pkg::TPM_W-1:0] : trial[tdcs_pkg::TPM_W-1:0];
        end
    end

    assign o_busy     = r_busy | r_done;
    assign o_res.done = r_done;
    assign o_res.quot = r_acc;
    assign o_res.rem  = r_rem;

endmodule

[hw/rtl/timed_dispense_cooldown_sequencer_core.sv]
// Channel   Direction  Signals                                     Moves
// s_axis    in         s_axis_tvalid/tready/tdata[7:0]             one tick item
// m_axis    out        m_axis_tvalid/tready/tdata[39:0]            one status item per tick
// cfg       in         i_cfg_valid/o_cfg_ready/i_cfg_index/i_cfg_data  register write
//
// One item per cycle unless stalled; each result is registered as its tick is taken.
// A write to ticks_per_minute starts a bit-serial divider that rebuilds the elapsed
// cooldown minutes from the cooldown timer: both ports stall while it runs.
// Synchronous active-low reset restores config and control state, not output data.
// Outside a divider pass, the input stalls only while the output register is full and
// not being taken.
module timed_dispense_cooldown_sequencer_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [0] proximity_clear, [1] mode_button, [2] amount_button, [3] cooldown_button
    input  logic [tdcs_pkg::IN_W-1:0]           s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [1:0] servo_command, [2] dispensing, [3] cooldown_running, [8:4] cycle_number,
    // [12:9] cycle_total, [13] mode_now, [15:14] amount_now, [18:16] cooldown_choice,
    // [28:19] cooldown_minutes, [38:29] remaining_minutes
    output logic [tdcs_pkg::OUT_W-1:0]          m_axis_tdata,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [tdcs_pkg::REG_IDX_W-1:0]      i_cfg_index,
    input  logic [tdcs_pkg::TPM_W-1:0]          i_cfg_data
);

    localparam int CTB = tdcs_pkg::COOL_TIMER_BITS;

    logic [tdcs_pkg::OPEN_W-1:0]   r_open_ticks;
    logic [tdcs_pkg::TPM_W-1:0]    r_tpm;
    logic [tdcs_pkg::CYC_W-1:0]    r_cyc_low;
    logic [tdcs_pkg::CYC_W-1:0]    r_cyc_med;
    logic [tdcs_pkg::CYC_W-1:0]    r_cyc_high;

    logic [tdcs_pkg::BTN_W-1:0]    r_prev_btn,   n_prev_btn;
    logic                          r_prev_prox,  n_prev_prox;
    logic                          r_mode,       n_mode;
    logic [tdcs_pkg::AMT_W-1:0]    r_amount,     n_amount;
    logic [tdcs_pkg::CHOICE_W-1:0] r_choice,     n_choice;
    logic                          r_run,        n_run;
    logic                          r_closing,    n_closing;
    logic [tdcs_pkg::CNT_W-1:0]    r_cyc_cnt,    n_cyc_cnt;
    logic [tdcs_pkg::CYC_W-1:0]    r_cyc_lim,    n_cyc_lim;
    logic [tdcs_pkg::PHASE_W-1:0]  r_phase,      n_phase;
    logic                          r_cool,       n_cool;
    logic [CTB-1:0]                r_cool_timer, n_cool_timer;
    logic [CTB-1:0]                r_cool_q,     n_cool_q;
    logic [tdcs_pkg::TPM_W-1:0]    r_cool_r,     n_cool_r;

    logic                          r_out_valid;
    logic [tdcs_pkg::OUT_W-1:0]    r_out_data;
    logic [tdcs_pkg::OUT_W-1:0]    n_out_data;

    logic                          in_accept;
    logic                          cfg_accept;
    logic                          div_busy;
    tdcs_pkg::t_div_res            div_res;

    logic                          prox;
    logic [tdcs_pkg::BTN_W-1:0]    btn;
    logic [tdcs_pkg::BTN_W-1:0]    pressed;
    tdcs_pkg::t_servo_cmd          cmd;
    logic [2:0]                    amt_inc;
    logic [3:0]                    ch_inc;
    logic [3:0]                    ch_mod;
    logic [tdcs_pkg::MIN_W-1:0]    minutes;
    logic [tdcs_pkg::MIN_W-1:0]    remaining;
    logic [tdcs_pkg::PHASE_W:0]    ph_next;
    logic [tdcs_pkg::TPM_W:0]      r_inc;
    logic [tdcs_pkg::DUR_W-1:0]    dur;

    assign cfg_accept    = i_cfg_valid & o_cfg_ready;
    assign o_cfg_ready   = ~div_busy;
    assign s_axis_tready = ~div_busy & (~r_out_valid | m_axis_tready);
    assign in_accept     = s_axis_tvalid & s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    tdcs_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (cfg_accept && (i_cfg_index == tdcs_pkg::REG_TICKS_PER_MIN)),
        .i_dividend (r_cool_timer),
        .i_divisor  (i_cfg_data),
        .o_busy     (div_busy),
        .o_res      (div_res)
    );

    always_comb begin
        prox    = s_axis_tdata[0];
        btn     = s_axis_tdata[3:1];
        pressed = btn & ~r_prev_btn;
        cmd     = tdcs_pkg::CMD_NONE;

        n_prev_btn   = btn;
        n_prev_prox  = r_prev_prox;
        n_mode       = r_mode;
        n_amount     = r_amount;
        n_choice     = r_choice;
        n_run        = r_run;
        n_closing    = r_closing;
        n_cyc_cnt    = r_cyc_cnt;
        n_cyc_lim    = r_cyc_lim;
        n_phase      = r_phase;
        n_cool       = r_cool;
        n_cool_timer = r_cool_timer;
        n_cool_q     = r_cool_q;
        n_cool_r     = r_cool_r;

        if (pressed[tdcs_pkg::BTN_MODE]) begin
            n_mode   = ~r_mode;
            n_choice = '0;
            if (r_cool) begin
                n_cool      = 1'b0;
                n_prev_prox = 1'b1;
            end
        end

        amt_inc = {1'b0, r_amount} + 3'd1;
        if (pressed[tdcs_pkg::BTN_AMOUNT]) begin
            n_amount = (amt_inc >= 3'(tdcs_pkg::AMOUNT_COUNT))
                     ? 2'(amt_inc - 3'(tdcs_pkg::AMOUNT_COUNT)) : amt_inc[1:0];
        end

        ch_inc = {1'b0, n_choice} + 4'd1;
        ch_mod = n_mode ? 4'(tdcs_pkg::ANIMAL_LEN) : 4'(tdcs_pkg::HUMAN_LEN);
        if (pressed[tdcs_pkg::BTN_COOL]) begin
            n_choice = (ch_inc >= ch_mod) ? 3'(ch_inc - ch_mod) : ch_inc[2:0];
        end

        minutes = tdcs_pkg::table_minutes(n_mode, n_choice);

        if (!n_cool && !r_run) begin
            if (!prox && n_prev_prox) begin
                cmd       = tdcs_pkg::CMD_OPEN;
                n_run     = 1'b1;
                n_phase   = '0;
                n_closing = 1'b0;
                n_cyc_cnt = tdcs_pkg::CNT_W'(1);
                case (n_amount)
                    2'd0:    n_cyc_lim = r_cyc_low;
                    2'd1:    n_cyc_lim = r_cyc_med;
                    default: n_cyc_lim = r_cyc_high;
                endcase
            end
            n_prev_prox = prox;
        end

        ph_next = {1'b0, n_phase} + 1'b1;
        if (n_run) begin
            if (!n_closing) begin
                if (ph_next > {1'b0, r_open_ticks}) begin
                    cmd       = tdcs_pkg::CMD_CLOSE;
                    n_closing = 1'b1;
                    n_phase   = '0;
                end else begin
                    n_phase = ph_next[tdcs_pkg::PHASE_W-1:0];
                end
            end else begin
                n_phase   = ph_next[tdcs_pkg::PHASE_W-1:0];
                n_cyc_cnt = n_cyc_cnt + 1'b1;
                if (n_cyc_cnt <= {1'b0, n_cyc_lim}) begin
                    cmd       = tdcs_pkg::CMD_OPEN;
                    n_closing = 1'b0;
                    n_phase   = '0;
                end else begin
                    cmd       = tdcs_pkg::CMD_CLOSE;
                    n_run     = 1'b0;
                    n_closing = 1'b0;
                    n_cyc_cnt = '0;
                    n_cyc_lim = tdcs_pkg::CYC_W'(1);
                    if (minutes != '0) begin
                        n_cool       = 1'b1;
                        n_cool_timer = '0;
                        n_cool_q     = '0;
                        n_cool_r     = '0;
                    end else begin
                        n_cool      = 1'b0;
                        n_prev_prox = 1'b1;
                    end
                end
            end
        end

        r_inc = {1'b0, n_cool_r} + 1'b1;
        dur   = tdcs_pkg::DUR_W'(minutes) * tdcs_pkg::DUR_W'(r_tpm);
        if (n_cool) begin
            if (n_cool_timer != {CTB{1'b1}}) begin
                n_cool_timer = n_cool_timer + 1'b1;
                if (r_tpm != '0) begin
                    if (r_inc == {1'b0, r_tpm}) begin
                        n_cool_r = '0;
                        n_cool_q = n_cool_q + 1'b1;
                    end else begin
                        n_cool_r = r_inc[tdcs_pkg::TPM_W-1:0];
                    end
                end
            end
            if (tdcs_pkg::CMP_W'(n_cool_timer) > tdcs_pkg::CMP_W'(dur)) begin
                n_cool      = 1'b0;
                n_prev_prox = 1'b1;
            end
        end

        remaining = minutes;
        if (n_cool && (r_tpm != '0)) begin
            remaining = (n_cool_q >= CTB'(minutes))
                      ? '0 : minutes - n_cool_q[tdcs_pkg::MIN_W-1:0];
        end

        n_out_data = {1'b0, remaining, minutes, n_choice, n_amount, n_mode,
                      n_cyc_lim, n_cyc_cnt, n_cool, n_run, cmd};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open_ticks <= tdcs_pkg::OPEN_TICKS_RST;
            r_tpm        <= tdcs_pkg::TPM_RST;
            r_cyc_low    <= tdcs_pkg::CYCLES_LOW_RST;
            r_cyc_med    <= tdcs_pkg::CYCLES_MED_RST;
            r_cyc_high   <= tdcs_pkg::CYCLES_HIGH_RST;
        end else if (cfg_accept) begin
            case (i_cfg_index)
                tdcs_pkg::REG_OPEN_TICKS:    r_open_ticks <= i_cfg_data[tdcs_pkg::OPEN_W-1:0];
                tdcs_pkg::REG_TICKS_PER_MIN: r_tpm        <= i_cfg_data;
                tdcs_pkg::REG_CYCLES_LOW:    r_cyc_low    <= i_cfg_data[tdcs_pkg::CYC_W-1:0];
                tdcs_pkg::REG_CYCLES_MED:    r_cyc_med    <= i_cfg_data[tdcs_pkg::CYC_W-1:0];
                tdcs_pkg::REG_CYCLES_HIGH:   r_cyc_high   <= i_cfg_data[tdcs_pkg::CYC_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_btn   <= '1;
            r_prev_prox  <= 1'b1;
            r_mode       <= 1'b0;
            r_amount     <= '0;
            r_choice     <= '0;
            r_run        <= 1'b0;
            r_closing    <= 1'b0;
            r_cyc_cnt    <= '0;
            r_cyc_lim    <= tdcs_pkg::CYC_W'(1);
            r_phase      <= '0;
            r_cool       <= 1'b0;
            r_cool_timer <= '0;
            r_cool_q     <= '0;
            r_cool_r     <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (div_res.done) begin
                r_cool_q <= div_res.quot;
                r_cool_r <= div_res.rem;
            end
            if (in_accept) begin
                r_prev_btn   <= n_prev_btn;
                r_prev_prox  <= n_prev_prox;
                r_mode       <= n_mode;
                r_amount     <= n_amount;
                r_choice     <= n_choice;
                r_run        <= n_run;
                r_closing    <= n_closing;
                r_cyc_cnt    <= n_cyc_cnt;
                r_cyc_lim    <= n_cyc_lim;
                r_phase      <= n_phase;
                r_cool       <= n_cool;
                r_cool_timer <= n_cool_timer;
                r_cool_q     <= n_cool_q;
                r_cool_r     <= n_cool_r;
                r_out_valid  <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out_data <= n_out_data;
        end
    end

endmodule

[tb/sv/dispense_status_checker.sv]
`timescale 1ns / 1ps

module dispense_status_checker
    import tdcs_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_tick_valid,
    input  logic                 i_tick_ready,
    input  logic [IN_W-1:0]      i_tick_data,
    input  logic                 i_status_valid,
    input  logic                 i_status_ready,
    input  logic [OUT_W-1:0]     i_status_data,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [REG_IDX_W-1:0] i_cfg_index,
    input  logic [TPM_W-1:0]     i_cfg_data,
    output int                   o_pending,
    output int                   o_fail_count
);

    // lowest bit is the last field
    typedef struct packed {
        logic [MIN_W-1:0]    remaining;
        logic [MIN_W-1:0]    minutes;
        logic [CHOICE_W-1:0] choice;
        logic [AMT_W-1:0]    amount;
        logic                mode;
        logic [CYC_W-1:0]    cycle_tot;
        logic [CNT_W-1:0]    cycle_no;
        logic                cooling;
        logic                dispensing;
        t_servo_cmd          servo;
    } t_status;

    logic [OPEN_W-1:0]          cf_open;
    logic [TPM_W-1:0]           cf_tpm;
    logic [CYC_W-1:0]           cf_low;
    logic [CYC_W-1:0]           cf_med;
    logic [CYC_W-1:0]           cf_high;

    logic [BTN_W-1:0]           prev_btn;
    logic                       prev_prox;
    logic                       mode_r;
    logic [AMT_W-1:0]           amount_r;
    logic [CHOICE_W-1:0]        choice_r;
    logic                       run_on;
    logic                       closing;
    logic [CNT_W-1:0]           cyc_cnt;
    logic [CYC_W-1:0]           cyc_lim;
    logic [PHASE_W-1:0]         phase_t;
    logic                       cool_on;
    logic [COOL_TIMER_BITS-1:0] cool_t;

    t_status status_expect_q[$];

    function automatic int selected_minutes();
        if (!mode_r) begin
            case (choice_r)
                3'd1: return 5;
                3'd2: return 10;
                3'd3: return 15;
                3'd4: return 30;
                3'd5: return 45;
                3'd6: return 60;
                default: return 0;
            endcase
        end
        case (choice_r)
            3'd0: return 30;
            3'd1: return 60;
            3'd2: return 120;
            3'd3: return 240;
            3'd4: return 480;
            3'd5: return 720;
            default: return 0;
        endcase
    endfunction

    task automatic advance_tick(input logic [3:0] tick, output t_status st);
        logic [BTN_W-1:0] btn;
        logic [BTN_W-1:0] pressed;
        logic             prox;
        logic [PHASE_W:0] nxt_phase;
        t_servo_cmd       cmd;
        int               dur;
        int               minutes;
        int               remaining;
        int               elapsed;
        prox    = tick[0];
        btn     = tick[3:1];
        pressed = btn & ~prev_btn;
        cmd     = CMD_NONE;

        if (pressed[BTN_MODE]) begin
            mode_r   = ~mode_r;
            choice_r = '0;
            if (cool_on) begin
                cool_on   = 1'b0;
                prev_prox = 1'b1;
            end
        end
        if (pressed[BTN_AMOUNT])
            amount_r = AMT_W'((int'(amount_r) + 1) % AMOUNT_COUNT);
        if (pressed[BTN_COOL])
            choice_r = CHOICE_W'((int'(choice_r) + 1) % (mode_r ? ANIMAL_LEN : HUMAN_LEN));
        prev_btn = btn;

        if (!cool_on && !run_on) begin
            if (!prox && prev_prox) begin
                cmd     = CMD_OPEN;
                run_on  = 1'b1;
                phase_t = '0;
                cyc_lim = (amount_r == 2'd0) ? cf_low : (amount_r == 2'd1) ? cf_med : cf_high;
                cyc_cnt = CNT_W'(1);
                closing = 1'b0;
            end
            prev_prox = prox;
        end

        if (run_on) begin
            nxt_phase = {1'b0, phase_t} + 1'b1;
            if (!closing) begin
                if (nxt_phase > {1'b0, cf_open}) begin
                    cmd     = CMD_CLOSE;
                    closing = 1'b1;
                    phase_t = '0;
                end else begin
                    phase_t = nxt_phase[PHASE_W-1:0];
                end
            end else begin
                phase_t = nxt_phase[PHASE_W-1:0];
                cyc_cnt = cyc_cnt + 1'b1;
                if (cyc_cnt <= {1'b0, cyc_lim}) begin
                    cmd     = CMD_OPEN;
                    closing = 1'b0;
                    phase_t = '0;
                end else begin
                    // run over: cooldown only for a nonzero table entry
                    cmd     = CMD_CLOSE;
                    run_on  = 1'b0;
                    closing = 1'b0;
                    cyc_cnt = '0;
                    cyc_lim = CYC_W'(1);
                    if (selected_minutes() > 0) begin
                        cool_on = 1'b1;
                        cool_t  = '0;
                    end else begin
                        cool_on   = 1'b0;
                        prev_prox = 1'b1;
                    end
                end
            end
        end

        if (cool_on) begin
            if (cool_t != {COOL_TIMER_BITS{1'b1}})
                cool_t = cool_t + 1'b1;
            dur = selected_minutes() * int'(cf_tpm);
            if (int'(cool_t) > dur) begin
                cool_on   = 1'b0;
                prev_prox = 1'b1;
            end
        end

        minutes   = selected_minutes();
        remaining = minutes;
        if (cool_on && cf_tpm != '0) begin
            elapsed   = int'(cool_t) / int'(cf_tpm);
            remaining = (elapsed >= minutes) ? 0 : minutes - elapsed;
        end

        st.servo      = cmd;
        st.dispensing = run_on;
        st.cooling    = cool_on;
        st.cycle_no   = cyc_cnt;
        st.cycle_tot  = cyc_lim;
        st.mode       = mode_r;
        st.amount     = amount_r;
        st.choice     = choice_r;
        st.minutes    = MIN_W'(minutes);
        st.remaining  = MIN_W'(remaining);
    endtask

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got) begin
            if (o_fail_count < 10)
                $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, name, want, got);
            o_fail_count = o_fail_count + 1;
        end
    endtask

    always @(posedge i_clk) begin
        t_status got;
        t_status want;
        t_status nxt;
        if (!i_rst_n) begin
            cf_open      = OPEN_TICKS_RST;
            cf_tpm       = TPM_RST;
            cf_low       = CYCLES_LOW_RST;
            cf_med       = CYCLES_MED_RST;
            cf_high      = CYCLES_HIGH_RST;
            prev_btn     = '1;
            prev_prox    = 1'b1;
            mode_r       = 1'b0;
            amount_r     = '0;
            choice_r     = '0;
            run_on       = 1'b0;
            closing      = 1'b0;
            cyc_cnt      = '0;
            cyc_lim      = CYC_W'(1);
            phase_t      = '0;
            cool_on      = 1'b0;
            cool_t       = '0;
            o_fail_count = 0;
            status_expect_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_OPEN_TICKS:    cf_open = i_cfg_data[OPEN_W-1:0];
                    REG_TICKS_PER_MIN: cf_tpm  = i_cfg_data;
                    REG_CYCLES_LOW:    cf_low  = i_cfg_data[CYC_W-1:0];
                    REG_CYCLES_MED:    cf_med  = i_cfg_data[CYC_W-1:0];
                    REG_CYCLES_HIGH:   cf_high = i_cfg_data[CYC_W-1:0];
                    default: ;
                endcase
            end
            if (i_status_valid && i_status_ready) begin
                got = i_status_data[$bits(t_status)-1:0];
                if (status_expect_q.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("%0t: status item with none expected: %h",
                                 $realtime, i_status_data);
                    o_fail_count = o_fail_count + 1;
                end else begin
                    want = status_expect_q.pop_front();
                    compare_field("servo_command", int'(want.servo), int'(got.servo));
                    compare_field("dispensing", int'(want.dispensing), int'(got.dispensing));
                    compare_field("cooldown_running", int'(want.cooling), int'(got.cooling));
                    compare_field("cycle_number", int'(want.cycle_no), int'(got.cycle_no));
                    compare_field("cycle_total", int'(want.cycle_tot), int'(got.cycle_tot));
                    compare_field("mode_now", int'(want.mode), int'(got.mode));
                    compare_field("amount_now", int'(want.amount), int'(got.amount));
                    compare_field("cooldown_choice", int'(want.choice), int'(got.choice));
                    compare_field("cooldown_minutes", int'(want.minutes), int'(got.minutes));
                    compare_field("remaining_minutes", int'(want.remaining),
                                  int'(got.remaining));
                end
            end
            if (i_tick_valid && i_tick_ready) begin
                advance_tick(i_tick_data[3:0], nxt);
                status_expect_q.push_back(nxt);
            end
        end
        o_pending = status_expect_q.size();
    end

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps

module tb;
    import tdcs_pkg::*;

    localparam int CYCLE_LIMIT    = 400000;
    localparam int DRAIN_CYCLES   = 4;
    localparam int RX_HOLD_CYCLES = 80;

    localparam logic [REG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [IN_W-1:0]      s_axis_tdata;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [OUT_W-1:0]     m_axis_tdata;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [REG_IDX_W-1:0] i_cfg_index;
    logic [TPM_W-1:0]     i_cfg_data;

    int                   pending_cnt;
    int                   fail_cnt;
    int                   cycle_cnt;

    logic                 steady;
    logic                 rx_hold;
    logic                 prox_lvl;
    logic [BTN_W-1:0]     btn_lvl;

    always #1 i_clk = ~i_clk;

    timed_dispense_cooldown_sequencer_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    dispense_status_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_tick_valid   (s_axis_tvalid),
        .i_tick_ready   (s_axis_tready),
        .i_tick_data    (s_axis_tdata),
        .i_status_valid (m_axis_tvalid),
        .i_status_ready (m_axis_tready),
        .i_status_data  (m_axis_tdata),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_pending      (pending_cnt),
        .o_fail_count   (fail_cnt)
    );

    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold) begin
                // hold off so the output fills and the input stalls
                rx_hold = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge i_clk);
            end else begin
                m_axis_tready <= steady || ($urandom_range(99) >= 28);
            end
        end
    end

    initial begin
        cycle_cnt = 0;
        while (cycle_cnt <= CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt = cycle_cnt + 1;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic push_tick(input logic [3:0] bits);
        while (!steady && $urandom_range(99) < 28) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_W - 4){1'b0}}, bits};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_cnt != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [TPM_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    task automatic program_regs(input int open_t, input int tpm, input int low,
                                input int med, input int high);
        wait_drained();
        write_reg(REG_OPEN_TICKS, TPM_W'(open_t));
        write_reg(REG_TICKS_PER_MIN, TPM_W'(tpm));
        write_reg(REG_CYCLES_LOW, TPM_W'(low));
        write_reg(REG_CYCLES_MED, TPM_W'(med));
        write_reg(REG_CYCLES_HIGH, TPM_W'(high));
        i_cfg_valid <= 1'b0;
    endtask

    // mostly plausible traffic: slow proximity changes, short button presses
    task automatic run_phase(input int n, input int steady_n, input int hold_at);
        logic [3:0] bits;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < 10) begin
                bits = 4'($urandom);
            end else begin
                if ($urandom_range(99) < (prox_lvl ? 6 : 15))
                    prox_lvl = ~prox_lvl;
                for (int b = 0; b < BTN_W; b++) begin
                    if (btn_lvl[b])
                        btn_lvl[b] = ($urandom_range(1) == 1);
                    else
                        btn_lvl[b] = ($urandom_range(99) < 3);
                end
                bits = {btn_lvl, prox_lvl};
            end
            steady = (i < steady_n);
            if (i == hold_at)
                rx_hold = 1'b1;
            push_tick(bits);
        end
        steady = 1'b0;
    endtask

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = REG_OPEN_TICKS;
        i_cfg_data    = '0;
        steady        = 1'b0;
        rx_hold       = 1'b0;
        prox_lvl      = 1'b1;
        btn_lvl       = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // item bits: cooldown, amount, mode, proximity
        push_tick(4'b1111);
        push_tick(4'b0001);
        push_tick(4'b0011);
        push_tick(4'b0001);
        push_tick(4'b0011);
        push_tick(4'b0001);

        program_regs(0, 0, 0, 1, 2);
        write_reg(REG_SPARE_LO, '1);
        write_reg(REG_SPARE_HI, TPM_W'(3));
        i_cfg_valid <= 1'b0;

        push_tick(4'b0101);
        push_tick(4'b0001);
        push_tick(4'b1001);
        push_tick(4'b0000);
        push_tick(4'b0000);
        push_tick(4'b0000);
        push_tick(4'b0101);
        push_tick(4'b0000);
        push_tick(4'b0000);
        push_tick(4'b0000);
        push_tick(4'b0000);
        push_tick(4'b0101);
        push_tick(4'b0000);
        push_tick(4'b0000);
        push_tick(4'b1111);
        push_tick(4'b1110);
        push_tick(4'b0000);
        push_tick(4'b0000);
        push_tick(4'b0001);

        program_regs(3, 1, 1, 2, 3);
        run_phase(100, 0, 60);
        program_regs(1, 2, 15, 0, 4);
        run_phase(80, 0, -1);
        program_regs(0, 8191, 2, 5, 1);
        run_phase(80, 0, -1);
        program_regs($urandom_range(6), $urandom_range(5), $urandom_range(15),
                     $urandom_range(15), $urandom_range(15));
        run_phase(80, 0, -1);
        program_regs(1023, 3, 1, 1, 1);
        run_phase(1060, 400, -1);

        wait_drained();
        if (fail_cnt == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

[files.f]
hw/rtl/tdcs_pkg.sv
hw/rtl/tdcs_div.sv
hw/rtl/timed_dispense_cooldown_sequencer_core.sv
tb/sv/dispense_status_checker.sv
tb/sv/tb.sv
